### rtl/core/pat_pkg.sv
// pat_pkg: shared types, codes and the control store of the packed array table
// holds the opcode and status codes, the control word layout and the microprogram
// used by the datapath, the top level and the checker
package pat_pkg;

  localparam int OP_W     = 3;
  localparam int POS_W    = 6;
  localparam int VAL_W    = 32;
  localparam int STAT_W   = 3;
  localparam int SLOT_W   = 5;
  localparam int OCC_W    = 6;
  localparam int MAX_RESULTS = 32;
  localparam int N_W      = 6;
  localparam int UPC_W    = 5;

  typedef enum logic [OP_W-1:0] {
    OP_APPEND     = 3'd0,
    OP_LIST       = 3'd1,
    OP_INSERT     = 3'd2,
    OP_DEL_LAST   = 3'd3,
    OP_DEL_VALUE  = 3'd4,
    OP_SEARCH     = 3'd5
  } opcode_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK        = 3'd0,
    ST_FULL      = 3'd1,
    ST_EMPTY     = 3'd2,
    ST_NOT_FOUND = 3'd3,
    ST_BAD_POS   = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    RD_NONE   = 2'd0,
    RD_AT_I   = 2'd1,
    RD_AT_IM1 = 2'd2
  } rd_sel_t;

  typedef enum logic [2:0] {
    WR_NONE       = 3'd0,
    WR_VAL_COUNT  = 3'd1,
    WR_VAL_POS    = 3'd2,
    WR_RD_I       = 3'd3,
    WR_RD_KEPT_NE = 3'd4
  } wr_sel_t;

  typedef enum logic [2:0] {
    I_HOLD  = 3'd0,
    I_ZERO  = 3'd1,
    I_COUNT = 3'd2,
    I_INC   = 3'd3,
    I_DEC   = 3'd4
  } i_op_t;

  typedef enum logic [1:0] {
    CNT_HOLD = 2'd0,
    CNT_INC  = 2'd1,
    CNT_DEC  = 2'd2,
    CNT_KEPT = 2'd3
  } cnt_op_t;

  typedef enum logic [1:0] {
    AUX_NONE   = 2'd0,
    AUX_CLR_KH = 2'd1,
    AUX_CLR_N  = 2'd2,
    AUX_HIT    = 2'd3
  } aux_op_t;

  typedef enum logic [1:0] {
    EM_NONE   = 2'd0,
    EM_STATUS = 2'd1,
    EM_LIST   = 2'd2,
    EM_MATCH  = 2'd3
  } emit_t;

  typedef enum logic [3:0] {
    C_NEVER     = 4'd0,
    C_ALWAYS    = 4'd1,
    C_FULL      = 4'd2,
    C_EMPTY     = 4'd3,
    C_POS_BAD   = 4'd4,
    C_I_LE_POS  = 4'd5,
    C_I_DONE    = 4'd6,
    C_KEPT_EQ   = 4'd7,
    C_HITS_ZERO = 4'd8,
    C_SCAN_END  = 4'd9
  } cond_t;

  typedef struct packed {
    logic             dispatch;
    rd_sel_t          rd_sel;
    wr_sel_t          wr_sel;
    i_op_t            i_op;
    cnt_op_t          cnt_op;
    aux_op_t          aux_op;
    emit_t            emit;
    status_t          status;
    cond_t            cond;
    logic [UPC_W-1:0] target;
  } ctl_t;

  typedef struct packed {
    logic full;
    logic empty;
    logic pos_bad;
    logic i_le_pos;
    logic i_done;
    logic kept_eq;
    logic hits_zero;
    logic scan_end;
    logic eq;
    logic last_list;
    logic last_match;
  } flags_t;

  typedef struct packed {
    logic [SLOT_W-1:0]       slot;
    logic signed [VAL_W-1:0] entry;
    logic [OCC_W-1:0]        occupancy;
  } view_t;

  // microprogram addresses
  localparam logic [UPC_W-1:0] S_IDLE    = 5'd0;
  localparam logic [UPC_W-1:0] S_E_OK    = 5'd1;
  localparam logic [UPC_W-1:0] S_E_FULL  = 5'd2;
  localparam logic [UPC_W-1:0] S_E_EMPTY = 5'd3;
  localparam logic [UPC_W-1:0] S_E_NF    = 5'd4;
  localparam logic [UPC_W-1:0] S_E_BAD   = 5'd5;
  localparam logic [UPC_W-1:0] S_A0      = 5'd6;
  localparam logic [UPC_W-1:0] S_A1      = 5'd7;
  localparam logic [UPC_W-1:0] S_D0      = 5'd8;
  localparam logic [UPC_W-1:0] S_D1      = 5'd9;
  localparam logic [UPC_W-1:0] S_I0      = 5'd10;
  localparam logic [UPC_W-1:0] S_I1      = 5'd11;
  localparam logic [UPC_W-1:0] S_I2      = 5'd12;
  localparam logic [UPC_W-1:0] S_I3      = 5'd13;
  localparam logic [UPC_W-1:0] S_I4      = 5'd14;
  localparam logic [UPC_W-1:0] S_V0      = 5'd15;
  localparam logic [UPC_W-1:0] S_V1      = 5'd16;
  localparam logic [UPC_W-1:0] S_V2      = 5'd17;
  localparam logic [UPC_W-1:0] S_V3      = 5'd18;
  localparam logic [UPC_W-1:0] S_V4      = 5'd19;
  localparam logic [UPC_W-1:0] S_S0      = 5'd20;
  localparam logic [UPC_W-1:0] S_S1      = 5'd21;
  localparam logic [UPC_W-1:0] S_S2      = 5'd22;
  localparam logic [UPC_W-1:0] S_S3      = 5'd23;
  localparam logic [UPC_W-1:0] S_S4      = 5'd24;
  localparam logic [UPC_W-1:0] S_S5      = 5'd25;
  localparam logic [UPC_W-1:0] S_L0      = 5'd26;
  localparam logic [UPC_W-1:0] S_L1      = 5'd27;
  localparam logic [UPC_W-1:0] S_L2      = 5'd28;

  localparam ctl_t CTL_NOP = '{
    dispatch: 1'b0,
    rd_sel:   RD_NONE,
    wr_sel:   WR_NONE,
    i_op:     I_HOLD,
    cnt_op:   CNT_HOLD,
    aux_op:   AUX_NONE,
    emit:     EM_NONE,
    status:   ST_OK,
    cond:     C_NEVER,
    target:   S_IDLE
  };

  function automatic logic [UPC_W-1:0] entry_step(input logic [OP_W-1:0] op);
    logic [UPC_W-1:0] s;
    case (op)
      OP_APPEND:    s = S_A0;
      OP_LIST:      s = S_L0;
      OP_INSERT:    s = S_I0;
      OP_DEL_LAST:  s = S_D0;
      OP_DEL_VALUE: s = S_V0;
      OP_SEARCH:    s = S_S0;
      default:      s = S_IDLE;
    endcase
    return s;
  endfunction

  function automatic ctl_t ucode(input logic [UPC_W-1:0] upc);
    ctl_t w;
    w = CTL_NOP;
    case (upc)
      S_IDLE: w.dispatch = 1'b1;
      // single-beat status results
      S_E_OK: begin
        w.emit = EM_STATUS; w.status = ST_OK; w.cond = C_ALWAYS; w.target = S_IDLE;
      end
      S_E_FULL: begin
        w.emit = EM_STATUS; w.status = ST_FULL; w.cond = C_ALWAYS; w.target = S_IDLE;
      end
      S_E_EMPTY: begin
        w.emit = EM_STATUS; w.status = ST_EMPTY; w.cond = C_ALWAYS; w.target = S_IDLE;
      end
      S_E_NF: begin
        w.emit = EM_STATUS; w.status = ST_NOT_FOUND; w.cond = C_ALWAYS;
        w.target = S_IDLE;
      end
      S_E_BAD: begin
        w.emit = EM_STATUS; w.status = ST_BAD_POS; w.cond = C_ALWAYS;
        w.target = S_IDLE;
      end
      // append
      S_A0: begin
        w.cond = C_FULL; w.target = S_E_FULL;
      end
      S_A1: begin
        w.wr_sel = WR_VAL_COUNT; w.cnt_op = CNT_INC; w.cond = C_ALWAYS; w.target = S_E_OK;
      end
      // delete last
      S_D0: begin
        w.cond = C_EMPTY; w.target = S_E_EMPTY;
      end
      S_D1: begin
        w.cnt_op = CNT_DEC; w.cond = C_ALWAYS; w.target = S_E_OK;
      end
      // insert at position, shifting from the top down
      S_I0: begin
        w.cond = C_FULL; w.target = S_E_FULL;
      end
      S_I1: begin
        w.i_op = I_COUNT; w.cond = C_POS_BAD; w.target = S_E_BAD;
      end
      S_I2: begin
        w.rd_sel = RD_AT_IM1; w.cond = C_I_LE_POS; w.target = S_I4;
      end
      S_I3: begin
        w.wr_sel = WR_RD_I; w.i_op = I_DEC; w.cond = C_ALWAYS; w.target = S_I2;
      end
      S_I4: begin
        w.wr_sel = WR_VAL_POS; w.cnt_op = CNT_INC; w.cond = C_ALWAYS; w.target = S_E_OK;
      end
      // delete by value with compaction
      S_V0: begin
        w.i_op = I_ZERO; w.aux_op = AUX_CLR_KH; w.cond = C_EMPTY; w.target = S_E_EMPTY;
      end
      S_V1: begin
        w.rd_sel = RD_AT_I; w.cond = C_I_DONE; w.target = S_V3;
      end
      S_V2: begin
        w.wr_sel = WR_RD_KEPT_NE; w.i_op = I_INC; w.cond = C_ALWAYS; w.target = S_V1;
      end
      S_V3: begin
        w.cond = C_KEPT_EQ; w.target = S_E_NF;
      end
      S_V4: begin
        w.cnt_op = CNT_KEPT; w.cond = C_ALWAYS; w.target = S_E_OK;
      end
      // search: count hits, then report them
      S_S0: begin
        w.i_op = I_ZERO; w.aux_op = AUX_CLR_KH; w.cond = C_EMPTY; w.target = S_E_EMPTY;
      end
      S_S1: begin
        w.rd_sel = RD_AT_I; w.cond = C_I_DONE; w.target = S_S3;
      end
      S_S2: begin
        w.aux_op = AUX_HIT; w.i_op = I_INC; w.cond = C_ALWAYS; w.target = S_S1;
      end
      S_S3: begin
        w.i_op = I_ZERO; w.aux_op = AUX_CLR_N; w.cond = C_HITS_ZERO; w.target = S_E_NF;
      end
      S_S4: begin
        w.rd_sel = RD_AT_I; w.cond = C_SCAN_END; w.target = S_IDLE;
      end
      S_S5: begin
        w.emit = EM_MATCH; w.i_op = I_INC; w.cond = C_ALWAYS; w.target = S_S4;
      end
      // list
      S_L0: begin
        w.i_op = I_ZERO; w.aux_op = AUX_CLR_N; w.cond = C_EMPTY; w.target = S_E_EMPTY;
      end
      S_L1: begin
        w.rd_sel = RD_AT_I; w.cond = C_SCAN_END; w.target = S_IDLE;
      end
      S_L2: begin
        w.emit = EM_LIST; w.i_op = I_INC; w.cond = C_ALWAYS; w.target = S_L1;
      end
      default: begin
        w.cond = C_ALWAYS; w.target = S_IDLE;
      end
    endcase
    return w;
  endfunction

endpackage

### rtl/core/pat_if.sv
// pat_if: request and result channels of the packed array table
// valid/ready handshake with payload; widths from pat_pkg

interface pat_in_if;
  logic                            valid;
  logic                            ready;
  logic [pat_pkg::OP_W-1:0]        opcode;
  logic [pat_pkg::POS_W-1:0]       position;
  logic signed [pat_pkg::VAL_W-1:0] operand;

  modport source (output valid, output opcode, output position, output operand,
                  input ready);
  modport sink (input valid, input opcode, input position, input operand,
                output ready);
endinterface

interface pat_out_if;
  logic                             valid;
  logic                             ready;
  logic [pat_pkg::STAT_W-1:0]       status;
  logic [pat_pkg::SLOT_W-1:0]       slot;
  logic signed [pat_pkg::VAL_W-1:0] entry;
  logic [pat_pkg::OCC_W-1:0]        occupancy;
  logic                             last;

  modport source (output valid, output status, output slot, output entry,
                  output occupancy, output last, input ready);
  modport sink (input valid, input status, input slot, input entry,
                input occupancy, input last, output ready);
endinterface

### rtl/core/pat_datapath.sv
// pat_datapath: entry memory, count, index registers and compare flags
// executes one control word per advancing cycle; types from pat_pkg
module pat_datapath #(
  parameter int DEPTH     = 32,
  parameter int WORD_BITS = 32
) (
  input  logic                             clk,
  input  logic                             rst,
  input  pat_pkg::ctl_t                    ctl,
  input  logic                             go,
  input  logic                             load,
  input  logic [pat_pkg::POS_W-1:0]        position,
  input  logic signed [pat_pkg::VAL_W-1:0] operand,
  output pat_pkg::flags_t                  flags,
  output pat_pkg::view_t                   view
);

  localparam int CW  = $clog2(DEPTH + 1);
  localparam int AW  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int M1  = (CW > pat_pkg::N_W) ? CW : pat_pkg::N_W;
  localparam int M2  = (M1 > pat_pkg::POS_W) ? M1 : pat_pkg::POS_W;
  localparam int XW  = M2 + 1;

  logic [WORD_BITS-1:0]       mem [DEPTH];
  logic [WORD_BITS-1:0]       val;
  logic [WORD_BITS-1:0]       rdata;
  logic [pat_pkg::POS_W-1:0]  pos;
  logic [CW-1:0]              count;
  logic [CW-1:0]              i;
  logic [CW-1:0]              kept;
  logic [CW-1:0]              hits;
  logic [pat_pkg::N_W-1:0]    n;

  logic [XW-1:0] count_x, i_x, hits_x, n_x, pos_x;
  logic          eq;
  logic          we;
  logic [AW-1:0] wa;
  logic [AW-1:0] ra;
  logic [WORD_BITS-1:0] wd;
  logic          n_inc;

  assign count_x = XW'(count);
  assign i_x     = XW'(i);
  assign hits_x  = XW'(hits);
  assign n_x     = XW'(n);
  assign pos_x   = XW'(pos);
  assign eq      = (rdata == val);
  assign n_inc   = go && (ctl.emit == pat_pkg::EM_LIST ||
                          (ctl.emit == pat_pkg::EM_MATCH && eq));

  always_comb begin
    flags.full       = (count_x >= XW'(DEPTH));
    flags.empty      = (count == '0);
    flags.pos_bad    = (pos_x > count_x);
    flags.i_le_pos   = (i_x <= pos_x);
    flags.i_done     = (i_x == count_x);
    flags.kept_eq    = (kept == count);
    flags.hits_zero  = (hits == '0);
    flags.scan_end   = (i_x == count_x) || (n_x == XW'(pat_pkg::MAX_RESULTS));
    flags.eq         = eq;
    flags.last_list  = (i_x + XW'(1) == count_x) ||
                       (n_x + XW'(1) == XW'(pat_pkg::MAX_RESULTS));
    flags.last_match = (n_x + XW'(1) == hits_x) ||
                       (n_x + XW'(1) == XW'(pat_pkg::MAX_RESULTS));
  end

  always_comb begin
    view.slot      = pat_pkg::SLOT_W'(i);
    view.entry     = pat_pkg::VAL_W'($signed(rdata));
    view.occupancy = pat_pkg::OCC_W'(count);
  end

  // memory port selection
  always_comb begin
    if (ctl.rd_sel == pat_pkg::RD_AT_IM1) begin
      ra = AW'(i - CW'(1));
    end else begin
      ra = AW'(i);
    end
    we = 1'b0;
    wa = AW'(i);
    wd = rdata;
    case (ctl.wr_sel)
      pat_pkg::WR_VAL_COUNT: begin
        we = 1'b1; wa = AW'(count); wd = val;
      end
      pat_pkg::WR_VAL_POS: begin
        we = 1'b1; wa = AW'(pos); wd = val;
      end
      pat_pkg::WR_RD_I: begin
        we = 1'b1; wa = AW'(i); wd = rdata;
      end
      pat_pkg::WR_RD_KEPT_NE: begin
        we = !eq; wa = AW'(kept); wd = rdata;
      end
      default: begin
        we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (go && we) begin
      mem[wa] <= wd;
    end
    if (go && ctl.rd_sel != pat_pkg::RD_NONE) begin
      rdata <= mem[ra];
    end
    if (load) begin
      val <= WORD_BITS'(operand);
      pos <= position;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      i     <= '0;
      kept  <= '0;
      hits  <= '0;
      n     <= '0;
    end else if (go) begin
      case (ctl.i_op)
        pat_pkg::I_ZERO:  i <= '0;
        pat_pkg::I_COUNT: i <= count;
        pat_pkg::I_INC:   i <= i + CW'(1);
        pat_pkg::I_DEC:   i <= i - CW'(1);
        default:          i <= i;
      endcase
      case (ctl.cnt_op)
        pat_pkg::CNT_INC:  count <= count + CW'(1);
        pat_pkg::CNT_DEC:  count <= count - CW'(1);
        pat_pkg::CNT_KEPT: count <= kept;
        default:           count <= count;
      endcase
      case (ctl.aux_op)
        pat_pkg::AUX_CLR_KH: begin
          kept <= '0;
          hits <= '0;
        end
        pat_pkg::AUX_HIT: begin
          if (eq) begin
            hits <= hits + CW'(1);
          end
        end
        default: begin
        end
      endcase
      if (ctl.wr_sel == pat_pkg::WR_RD_KEPT_NE && !eq) begin
        kept <= kept + CW'(1);
      end
      if (ctl.aux_op == pat_pkg::AUX_CLR_N) begin
        n <= '0;
      end else if (n_inc) begin
        n <= n + pat_pkg::N_W'(1);
      end
    end
  end

endmodule

### rtl/core/packed_array_table_core.sv
// packed_array_table_core: packed table of signed words with append, insert,
// delete, search and list, run by a microprogram from pat_pkg over pat_datapath
//
//   channel | dir | beat payload                               | handshake
//   --------+-----+--------------------------------------------+------------
//   req     | in  | opcode, position, operand                  | valid/ready
//   rsp     | out | status, slot, entry, occupancy, last       | valid/ready
//
// one control word per cycle, except while the dispatch step waits on a request or a
// status or report step waits on a full result register; the entry memory needs a read
// step and a write or report step per entry touched. reset clears the step counter,
// count and result valid; entries hold no value until written and get no clearing
// pass. req is ready only in the dispatch step.
module packed_array_table_core #(
  parameter int DEPTH     = 32,
  parameter int WORD_BITS = 32
) (
  input logic       clk,
  input logic       rst,
  pat_in_if.sink    req,
  pat_out_if.source rsp
);

  logic [pat_pkg::UPC_W-1:0] upc;
  logic [pat_pkg::UPC_W-1:0] upc_next;
  pat_pkg::ctl_t             ctl;
  pat_pkg::flags_t           flags;
  pat_pkg::view_t            view;
  logic                      accept;
  logic                      out_free;
  logic                      go;
  logic                      jump;
  logic                      emit_fire;

  logic                             out_valid;
  logic [pat_pkg::STAT_W-1:0]       out_status;
  logic [pat_pkg::SLOT_W-1:0]       out_slot;
  logic signed [pat_pkg::VAL_W-1:0] out_entry;
  logic [pat_pkg::OCC_W-1:0]        out_occupancy;
  logic                             out_last;

  assign ctl       = pat_pkg::ucode(upc);
  assign req.ready = ctl.dispatch;
  assign accept    = req.valid && ctl.dispatch;
  assign out_free  = !out_valid || rsp.ready;
  assign go        = ctl.dispatch ? accept : (ctl.emit == pat_pkg::EM_NONE || out_free);
  assign emit_fire = go && (ctl.emit == pat_pkg::EM_STATUS || ctl.emit == pat_pkg::EM_LIST ||
                            (ctl.emit == pat_pkg::EM_MATCH && flags.eq));

  always_comb begin
    case (ctl.cond)
      pat_pkg::C_ALWAYS:    jump = 1'b1;
      pat_pkg::C_FULL:      jump = flags.full;
      pat_pkg::C_EMPTY:     jump = flags.empty;
      pat_pkg::C_POS_BAD:   jump = flags.pos_bad;
      pat_pkg::C_I_LE_POS:  jump = flags.i_le_pos;
      pat_pkg::C_I_DONE:    jump = flags.i_done;
      pat_pkg::C_KEPT_EQ:   jump = flags.kept_eq;
      pat_pkg::C_HITS_ZERO: jump = flags.hits_zero;
      pat_pkg::C_SCAN_END:  jump = flags.scan_end;
      default:              jump = 1'b0;
    endcase
  end

  always_comb begin
    if (!go) begin
      upc_next = upc;
    end else if (ctl.dispatch) begin
      upc_next = pat_pkg::entry_step(req.opcode);
    end else if (jump) begin
      upc_next = ctl.target;
    end else begin
      upc_next = upc + pat_pkg::UPC_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      upc <= pat_pkg::S_IDLE;
    end else begin
      upc <= upc_next;
    end
  end

  pat_datapath #(
    .DEPTH     (DEPTH),
    .WORD_BITS (WORD_BITS)
  ) u_datapath (
    .clk      (clk),
    .rst      (rst),
    .ctl      (ctl),
    .go       (go),
    .load     (accept),
    .position (req.position),
    .operand  (req.operand),
    .flags    (flags),
    .view     (view)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit_fire) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_fire) begin
      out_occupancy <= view.occupancy;
      if (ctl.emit == pat_pkg::EM_STATUS) begin
        out_status <= ctl.status;
        out_slot   <= '0;
        out_entry  <= '0;
        out_last   <= 1'b1;
      end else begin
        out_status <= pat_pkg::ST_OK;
        out_slot   <= view.slot;
        out_entry  <= view.entry;
        out_last   <= (ctl.emit == pat_pkg::EM_LIST) ? flags.last_list : flags.last_match;
      end
    end
  end

  assign rsp.valid     = out_valid;
  assign rsp.status    = out_status;
  assign rsp.slot      = out_slot;
  assign rsp.entry     = out_entry;
  assign rsp.occupancy = out_occupancy;
  assign rsp.last      = out_last;

endmodule

### rtl/core/pat_checker.sv
// pat_checker: port-level checks of packed_array_table_core
// bound to the top level below; codes from pat_pkg
module pat_checker (
  input logic                             clk,
  input logic                             rst,
  input logic                             req_valid,
  input logic                             req_ready,
  input logic [pat_pkg::OP_W-1:0]         req_opcode,
  input logic                             rsp_valid,
  input logic                             rsp_ready,
  input logic [pat_pkg::STAT_W-1:0]       rsp_status,
  input logic [pat_pkg::SLOT_W-1:0]       rsp_slot,
  input logic signed [pat_pkg::VAL_W-1:0] rsp_entry,
  input logic [pat_pkg::OCC_W-1:0]        rsp_occupancy,
  input logic                             rsp_last
);

  // stalled result beat holds
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status) && $stable(rsp_slot) &&
      $stable(rsp_entry) && $stable(rsp_occupancy) && $stable(rsp_last))
    else $error("result beat changed while stalled");

  // a real request keeps the table busy for at least the next cycle
  a_busy_after_op: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready && req_opcode <= pat_pkg::OP_SEARCH |=> !req_ready)
    else $error("request taken while previous one in flight");

  // error statuses are single final beats with no entry
  a_status_beat: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_status != pat_pkg::ST_OK |-> rsp_last && rsp_slot == '0 &&
      rsp_entry == '0)
    else $error("error status beat carries entry data");

  // reset empties the result register
  a_reset_clear: assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> !rsp_valid)
    else $error("result valid after reset");

endmodule

bind packed_array_table_core pat_checker u_pat_checker (
  .clk           (clk),
  .rst           (rst),
  .req_valid     (req.valid),
  .req_ready     (req.ready),
  .req_opcode    (req.opcode),
  .rsp_valid     (rsp.valid),
  .rsp_ready     (rsp.ready),
  .rsp_status    (rsp.status),
  .rsp_slot      (rsp.slot),
  .rsp_entry     (rsp.entry),
  .rsp_occupancy (rsp.occupancy),
  .rsp_last      (rsp.last)
);

### sim/tb_packed_array_table_core.sv
// tb_packed_array_table_core: self-checking bench for the packed array table core
// drives requests through pat_in_if, checks each result beat on pat_out_if against
// a shadow table kept here or the status scripted for a directed row; needs pat_pkg, pat_if and the core
module tb_packed_array_table_core;

  localparam int TABLE_DEPTH = 32;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int DRAIN_CYCLES = 200;
  localparam int N_DIRECTED = 23;
  localparam logic [pat_pkg::OP_W-1:0] OP_SPARE_6 = 3'd6;
  localparam logic [pat_pkg::OP_W-1:0] OP_SPARE_7 = 3'd7;

  typedef struct packed {
    pat_pkg::status_t                 status;
    logic [pat_pkg::SLOT_W-1:0]       slot;
    logic signed [pat_pkg::VAL_W-1:0] entry;
    logic [pat_pkg::OCC_W-1:0]        occupancy;
    logic                             last;
  } table_beat_t;

  typedef struct packed {
    logic [pat_pkg::OP_W-1:0]         op;
    logic [pat_pkg::POS_W-1:0]        pos;
    logic signed [pat_pkg::VAL_W-1:0] val;
    logic                             typed;
    pat_pkg::status_t                 st;
    logic [pat_pkg::OCC_W-1:0]        occ;
  } script_row_t;

  logic clk;
  logic rst;
  int   cycle_count = 0;
  int   mismatches = 0;
  int   send_idle = 13;
  int   rcv_idle = 59;

  table_beat_t                      pending_beats[$];
  table_beat_t                      fresh_beats[$];
  logic signed [pat_pkg::VAL_W-1:0] shadow [TABLE_DEPTH];
  int                               shadow_count = 0;
  logic signed [pat_pkg::VAL_W-1:0] value_pool [4];
  script_row_t                      dir_rows [N_DIRECTED];

  pat_in_if  req_ch ();
  pat_out_if rsp_ch ();

  packed_array_table_core dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  initial clk = 1'b0;
  always #2 clk = ~clk;

  task automatic flag_mismatch(input string msg);
    $display("mismatch at cycle %0d: %s", cycle_count, msg);
    mismatches++;
  endtask

  task automatic push_status(input pat_pkg::status_t st);
    fresh_beats.push_back('{status: st, slot: '0, entry: '0,
                            occupancy: pat_pkg::OCC_W'(shadow_count), last: 1'b1});
  endtask

  // shadow table: expected beats for one accepted request
  task automatic model_request(input logic [pat_pkg::OP_W-1:0] op,
                               input logic [pat_pkg::POS_W-1:0] pos,
                               input logic signed [pat_pkg::VAL_W-1:0] val);
    int kept;
    int hits;
    int seen;
    fresh_beats.delete();
    case (op)
      pat_pkg::OP_APPEND: begin
        if (shadow_count >= TABLE_DEPTH) begin
          push_status(pat_pkg::ST_FULL);
        end else begin
          shadow[shadow_count] = val;
          shadow_count++;
          push_status(pat_pkg::ST_OK);
        end
      end
      pat_pkg::OP_LIST: begin
        if (shadow_count == 0) begin
          push_status(pat_pkg::ST_EMPTY);
        end else begin
          for (int i = 0; i < shadow_count && i < pat_pkg::MAX_RESULTS; i++)
            fresh_beats.push_back('{status: pat_pkg::ST_OK, slot: pat_pkg::SLOT_W'(i),
                                    entry: shadow[i],
                                    occupancy: pat_pkg::OCC_W'(shadow_count),
                                    last: (i + 1 == shadow_count) ||
                                          (i + 1 == pat_pkg::MAX_RESULTS)});
        end
      end
      pat_pkg::OP_INSERT: begin
        if (shadow_count >= TABLE_DEPTH) begin
          push_status(pat_pkg::ST_FULL);
        end else if (int'(pos) > shadow_count) begin
          push_status(pat_pkg::ST_BAD_POS);
        end else begin
          for (int i = shadow_count; i > int'(pos); i--)
            shadow[i] = shadow[i-1];
          shadow[pos] = val;
          shadow_count++;
          push_status(pat_pkg::ST_OK);
        end
      end
      pat_pkg::OP_DEL_LAST: begin
        if (shadow_count == 0) begin
          push_status(pat_pkg::ST_EMPTY);
        end else begin
          shadow_count--;
          push_status(pat_pkg::ST_OK);
        end
      end
      pat_pkg::OP_DEL_VALUE: begin
        if (shadow_count == 0) begin
          push_status(pat_pkg::ST_EMPTY);
        end else begin
          kept = 0;
          for (int i = 0; i < shadow_count; i++)
            if (shadow[i] != val) begin
              shadow[kept] = shadow[i];
              kept++;
            end
          if (kept == shadow_count) begin
            push_status(pat_pkg::ST_NOT_FOUND);
          end else begin
            shadow_count = kept;
            push_status(pat_pkg::ST_OK);
          end
        end
      end
      pat_pkg::OP_SEARCH: begin
        if (shadow_count == 0) begin
          push_status(pat_pkg::ST_EMPTY);
        end else begin
          hits = 0;
          for (int i = 0; i < shadow_count; i++)
            if (shadow[i] == val) hits++;
          if (hits == 0) begin
            push_status(pat_pkg::ST_NOT_FOUND);
          end else begin
            seen = 0;
            for (int i = 0; i < shadow_count && seen < pat_pkg::MAX_RESULTS; i++)
              if (shadow[i] == val) begin
                seen++;
                fresh_beats.push_back('{status: pat_pkg::ST_OK,
                                        slot: pat_pkg::SLOT_W'(i), entry: shadow[i],
                                        occupancy: pat_pkg::OCC_W'(shadow_count),
                                        last: (seen == hits) ||
                                              (seen == pat_pkg::MAX_RESULTS)});
              end
          end
        end
      end
      default: begin
      end
    endcase
  endtask

  task automatic send_request(input logic [pat_pkg::OP_W-1:0] op,
                              input logic [pat_pkg::POS_W-1:0] pos,
                              input logic signed [pat_pkg::VAL_W-1:0] val,
                              input bit use_model);
    while ($urandom_range(0, 99) < send_idle) begin
      req_ch.valid <= 1'b0;
      @(posedge clk);
    end
    req_ch.valid    <= 1'b1;
    req_ch.opcode   <= op;
    req_ch.position <= pos;
    req_ch.operand  <= val;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    model_request(op, pos, val);
    if (use_model)
      foreach (fresh_beats[k]) pending_beats.push_back(fresh_beats[k]);
  endtask

  // fill with one value, then full-table search, list, refusals and a delete of that value
  task automatic fill_and_sweep();
    logic signed [pat_pkg::VAL_W-1:0] v;
    v = $urandom;
    while (shadow_count < TABLE_DEPTH) begin
      if ($urandom_range(0, 3) == 0)
        send_request(pat_pkg::OP_INSERT,
                     pat_pkg::POS_W'($urandom_range(0, shadow_count)), v, 1'b1);
      else
        send_request(pat_pkg::OP_APPEND, pat_pkg::POS_W'($urandom_range(0, 32)), v, 1'b1);
    end
    send_request(pat_pkg::OP_SEARCH, '0, v, 1'b1);
    send_request(pat_pkg::OP_LIST, '0, $urandom, 1'b1);
    send_request(pat_pkg::OP_APPEND, '0, $urandom, 1'b1);
    send_request(pat_pkg::OP_INSERT, pat_pkg::POS_W'($urandom_range(0, 32)), $urandom, 1'b1);
    send_request(pat_pkg::OP_DEL_VALUE, '0, v, 1'b1);
  endtask

  task automatic random_requests(input int n);
    int                               sent;
    int                               r;
    logic [pat_pkg::OP_W-1:0]         op;
    logic [pat_pkg::POS_W-1:0]        pos;
    logic signed [pat_pkg::VAL_W-1:0] val;
    sent = 0;
    while (sent < n) begin
      r = $urandom_range(0, 99);
      if (r < 25)      op = pat_pkg::OP_APPEND;
      else if (r < 45) op = pat_pkg::OP_INSERT;
      else if (r < 55) op = pat_pkg::OP_LIST;
      else if (r < 65) op = pat_pkg::OP_DEL_LAST;
      else if (r < 80) op = pat_pkg::OP_DEL_VALUE;
      else if (r < 98) op = pat_pkg::OP_SEARCH;
      else             op = ($urandom_range(0, 1) == 0) ? OP_SPARE_6 : OP_SPARE_7;
      r = $urandom_range(0, 99);
      if (r < 50) begin
        val = value_pool[$urandom_range(0, 3)];
      end else if (r < 75) begin
        val = $urandom;
      end else begin
        case ($urandom_range(0, 3))
          0: val = 32'sh7fffffff;
          1: val = 32'sh80000000;
          2: val = -32'sd1;
          default: val = 32'sd0;
        endcase
      end
      if ($urandom_range(0, 4) == 0)
        pos = pat_pkg::POS_W'($urandom_range(0, 32));
      else
        pos = pat_pkg::POS_W'($urandom_range(0, shadow_count));
      send_request(op, pos, val, 1'b1);
      if (op != OP_SPARE_6 && op != OP_SPARE_7) sent++;
    end
  endtask

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // result side: random stalls and beat checking
  always @(posedge clk) begin
    table_beat_t want;
    rsp_ch.ready <= ($urandom_range(0, 99) >= rcv_idle);
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      if (pending_beats.size() == 0) begin
        flag_mismatch("result beat with nothing pending");
      end else begin
        want = pending_beats.pop_front();
        if (rsp_ch.status !== want.status)
          flag_mismatch($sformatf("status %0d, want %0d", rsp_ch.status, want.status));
        if (rsp_ch.slot !== want.slot)
          flag_mismatch($sformatf("slot %0d, want %0d", rsp_ch.slot, want.slot));
        if (rsp_ch.entry !== want.entry)
          flag_mismatch($sformatf("entry %0d, want %0d", rsp_ch.entry, want.entry));
        if (rsp_ch.occupancy !== want.occupancy)
          flag_mismatch($sformatf("occupancy %0d, want %0d", rsp_ch.occupancy,
                                  want.occupancy));
        if (rsp_ch.last !== want.last)
          flag_mismatch($sformatf("last %0b, want %0b", rsp_ch.last, want.last));
      end
    end
  end

  initial begin
    rst             = 1'b1;
    req_ch.valid    = 1'b0;
    req_ch.opcode   = '0;
    req_ch.position = '0;
    req_ch.operand  = '0;
    rsp_ch.ready    = 1'b0;
    dir_rows = '{
      '{pat_pkg::OP_LIST,      6'd0,  32'sd0,        1'b1, pat_pkg::ST_EMPTY,     6'd0},
      '{pat_pkg::OP_DEL_LAST,  6'd0,  32'sd0,        1'b1, pat_pkg::ST_EMPTY,     6'd0},
      '{pat_pkg::OP_DEL_VALUE, 6'd0,  32'sd5,        1'b1, pat_pkg::ST_EMPTY,     6'd0},
      '{pat_pkg::OP_SEARCH,    6'd0,  32'sd5,        1'b1, pat_pkg::ST_EMPTY,     6'd0},
      '{pat_pkg::OP_INSERT,    6'd1,  32'sd9,        1'b1, pat_pkg::ST_BAD_POS,   6'd0},
      '{pat_pkg::OP_APPEND,    6'd0,  32'sh7fffffff, 1'b1, pat_pkg::ST_OK,        6'd1},
      '{pat_pkg::OP_APPEND,    6'd0,  32'sh80000000, 1'b1, pat_pkg::ST_OK,        6'd2},
      '{pat_pkg::OP_INSERT,    6'd0,  -32'sd1,       1'b1, pat_pkg::ST_OK,        6'd3},
      '{pat_pkg::OP_INSERT,    6'd3,  32'sd0,        1'b1, pat_pkg::ST_OK,        6'd4},
      '{pat_pkg::OP_INSERT,    6'd32, 32'sd1,        1'b1, pat_pkg::ST_BAD_POS,   6'd4},
      '{pat_pkg::OP_INSERT,    6'd5,  32'sd1,        1'b1, pat_pkg::ST_BAD_POS,   6'd4},
      '{pat_pkg::OP_LIST,      6'd0,  32'sd0,        1'b0, pat_pkg::ST_OK,        6'd0},
      '{pat_pkg::OP_SEARCH,    6'd0,  32'sh7fffffff, 1'b0, pat_pkg::ST_OK,        6'd0},
      '{pat_pkg::OP_SEARCH,    6'd0,  32'sd12345,    1'b1, pat_pkg::ST_NOT_FOUND, 6'd4},
      '{pat_pkg::OP_DEL_VALUE, 6'd0,  32'sd12345,    1'b1, pat_pkg::ST_NOT_FOUND, 6'd4},
      '{pat_pkg::OP_APPEND,    6'd0,  -32'sd1,       1'b1, pat_pkg::ST_OK,        6'd5},
      '{pat_pkg::OP_INSERT,    6'd1,  -32'sd1,       1'b1, pat_pkg::ST_OK,        6'd6},
      '{pat_pkg::OP_SEARCH,    6'd0,  -32'sd1,       1'b0, pat_pkg::ST_OK,        6'd0},
      '{pat_pkg::OP_DEL_VALUE, 6'd0,  -32'sd1,       1'b1, pat_pkg::ST_OK,        6'd3},
      '{OP_SPARE_6,            6'd63, -32'sd1,       1'b0, pat_pkg::ST_OK,        6'd0},
      '{OP_SPARE_7,            6'd0,  32'sh5a5a5a5a, 1'b0, pat_pkg::ST_OK,        6'd0},
      '{pat_pkg::OP_DEL_LAST,  6'd0,  32'sd0,        1'b1, pat_pkg::ST_OK,        6'd2},
      '{pat_pkg::OP_LIST,      6'd0,  32'sd0,        1'b0, pat_pkg::ST_OK,        6'd0}
    };
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (dir_rows[k]) begin
      send_request(dir_rows[k].op, dir_rows[k].pos, dir_rows[k].val, !dir_rows[k].typed);
      if (dir_rows[k].typed)
        pending_beats.push_back('{status: dir_rows[k].st, slot: '0, entry: '0,
                                  occupancy: dir_rows[k].occ, last: 1'b1});
    end

    for (int phase = 0; phase < 3; phase++) begin
      send_idle = (phase == 0) ? 13 : (phase == 1) ? 59 : 0;
      rcv_idle  = (phase == 0) ? 59 : (phase == 1) ? 13 : 0;
      foreach (value_pool[k]) value_pool[k] = $urandom;
      fill_and_sweep();
      random_requests(35);
    end
    req_ch.valid <= 1'b0;

    while (pending_beats.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (pending_beats.size() != 0)
      flag_mismatch($sformatf("%0d expected beats never arrived", pending_beats.size()));
    if (mismatches == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule
